// ===== rtl/pgjs_pkg.sv =====
`default_nettype none

package pgjs_pkg;

    // Record and result field widths
    localparam int ID_W    = 16;
    localparam int TS_W    = 32;
    localparam int GAP_W   = 16;
    localparam int JIT_W   = 40;
    localparam int SHIFT_W = 4;

    // Statistics state widths
    localparam int CNT_W   = 17;
    localparam int LOST_W  = 33;
    localparam int DIFF_W  = ID_W + 2;

    // Fixed point and timing defaults
    localparam int FRAC_BITS  = 8;
    localparam int TIME_WIDTH = 32;

    localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(4);
    localparam logic [SHIFT_W-1:0] SHIFT_MAX   = SHIFT_W'(8);

    localparam logic [JIT_W-1:0] ACC_MAX  = {JIT_W{1'b1}};
    localparam logic [63:0]      DV_LIMIT = {{(64-JIT_W){1'b0}}, ACC_MAX} >> FRAC_BITS;

    localparam logic [CNT_W-1:0]  GAP_MAX  = {CNT_W{1'b1}};
    localparam logic [LOST_W-1:0] LOST_MAX = {1'b0, {(LOST_W-1){1'b1}}};
    localparam logic [LOST_W-1:0] LOST_MIN = {1'b1, {(LOST_W-1){1'b0}}};

    // One quotient bit per divide step
    localparam int DIV_STEPS = LOST_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DRAIN,
        S_INIT,
        S_DIVIDE,
        S_FINISH,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic div_init;
        logic div_step;
        logic div_finish;
    } t_cmd;

    typedef struct packed {
        logic batch_end;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/pgjs_ifs.sv =====
`default_nettype none

// Packet record channel
interface pgjs_rec_if;
    logic                       valid;
    logic                       ready;
    logic [pgjs_pkg::ID_W-1:0]  seq_id;
    logic [pgjs_pkg::TS_W-1:0]  send_time;
    logic [pgjs_pkg::TS_W-1:0]  recv_time;
    logic                       last;

    modport source (output valid, seq_id, send_time, recv_time, last, input ready);
    modport sink   (input valid, seq_id, send_time, recv_time, last, output ready);
endinterface

// Batch result channel
interface pgjs_res_if;
    logic                        valid;
    logic                        ready;
    logic [pgjs_pkg::GAP_W-1:0]  mean_gap;
    logic [pgjs_pkg::JIT_W-1:0]  jitter_fixed;

    modport source (output valid, mean_gap, jitter_fixed, input ready);
    modport sink   (input valid, mean_gap, jitter_fixed, output ready);
endinterface

`default_nettype wire

// ===== rtl/pgjs_ctrl.sv =====
`default_nettype none

module pgjs_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  wire                  i_last_hint,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output pgjs_pkg::t_cmd       o_cmd,
    input  pgjs_pkg::t_sts       i_sts
);

    pgjs_pkg::t_state                 r_state, n_state;
    logic [pgjs_pkg::DCNT_W-1:0]      r_cnt, n_cnt;

    // State and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pgjs_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            pgjs_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
                if (i_in_valid && i_last_hint) begin
                    n_state = pgjs_pkg::S_DRAIN;
                end
            end
            pgjs_pkg::S_DRAIN: begin
                if (i_sts.batch_end) begin
                    n_state = pgjs_pkg::S_INIT;
                end
            end
            pgjs_pkg::S_INIT: begin
                o_cmd.div_init = 1'b1;
                n_cnt          = pgjs_pkg::DCNT_W'(pgjs_pkg::DIV_STEPS - 1);
                n_state        = pgjs_pkg::S_DIVIDE;
            end
            pgjs_pkg::S_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt - pgjs_pkg::DCNT_W'(1);
                if (r_cnt == '0) begin
                    n_state = pgjs_pkg::S_FINISH;
                end
            end
            pgjs_pkg::S_FINISH: begin
                o_cmd.div_finish = 1'b1;
                n_state          = pgjs_pkg::S_DONE;
            end
            pgjs_pkg::S_DONE: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = pgjs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pgjs_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/pgjs_dp.sv =====
`default_nettype none

module pgjs_dp #(
    parameter int TIME_WIDTH = pgjs_pkg::TIME_WIDTH
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  pgjs_pkg::t_cmd                   i_cmd,
    output pgjs_pkg::t_sts                   o_sts,
    input  wire                              i_cfg_we,
    input  wire  [pgjs_pkg::SHIFT_W-1:0]     i_cfg_wdata,
    input  wire  [pgjs_pkg::ID_W-1:0]        i_seq_id,
    input  wire  [pgjs_pkg::TS_W-1:0]        i_send_time,
    input  wire  [pgjs_pkg::TS_W-1:0]        i_recv_time,
    input  wire                              i_last,
    output logic [pgjs_pkg::GAP_W-1:0]       o_mean_gap,
    output logic [pgjs_pkg::JIT_W-1:0]       o_jitter_fixed
);

    localparam int WIDE_W = TIME_WIDTH + pgjs_pkg::TS_W;
    localparam int JW     = pgjs_pkg::JIT_W;
    localparam int LW     = pgjs_pkg::LOST_W;
    localparam int CW     = pgjs_pkg::CNT_W;
    localparam int DW     = pgjs_pkg::DIFF_W;

    // Configuration
    logic [pgjs_pkg::SHIFT_W-1:0] r_shift;

    // Stage 1: captured record
    logic                          r_s1_vld;
    logic                          r_s1_last;
    logic [pgjs_pkg::ID_W-1:0]     r_s1_id;
    logic [TIME_WIDTH-1:0]         r_s1_transit;

    // Previous record
    logic                          r_has_prev;
    logic [pgjs_pkg::ID_W-1:0]     r_prev_id;
    logic [TIME_WIDTH-1:0]         r_prev_transit;

    // Stage 2: per-pair deltas
    logic                          r_s2_vld;
    logic                          r_s2_has;
    logic                          r_s2_last;
    logic [DW-1:0]                 r_s2_lost;
    logic [JW-1:0]                 r_s2_dv;

    // Batch accumulators
    logic [CW-1:0]                 r_gap_count, n_gap_count;
    logic [LW-1:0]                 r_lost_total, n_lost_total;
    logic [JW-1:0]                 r_jitter_acc, n_jitter_acc;

    // Batch totals and divider
    logic [LW-1:0]                 r_fin_lost;
    logic [CW-1:0]                 r_fin_gap;
    logic [JW-1:0]                 r_jit_out;
    logic [LW-1:0]                 r_dvd;
    logic [CW-1:0]                 r_rem;
    logic                          r_neg;
    logic [pgjs_pkg::GAP_W-1:0]    r_mean_gap;

    logic [WIDE_W-1:0]             w_transit_wide;
    logic [TIME_WIDTH-1:0]         w_d_fwd, w_d_rev, w_mag;
    logic [63:0]                   w_mag64;
    logic [JW-1:0]                 w_dv;
    logic [DW-1:0]                 w_lost;
    logic                          w_lost_pos;
    logic [LW:0]                   w_lost_sum;
    logic [JW:0]                   w_up;
    logic                          w_ge;
    logic [JW-1:0]                 w_jdiff, w_jstep;
    logic [pgjs_pkg::SHIFT_W-1:0]  w_sh;
    logic [CW:0]                   w_rshift;
    logic                          w_qbit;

    // Transit time of the incoming record, modulo 2^TIME_WIDTH
    assign w_transit_wide = {{TIME_WIDTH{1'b0}}, i_recv_time}
                          - {{TIME_WIDTH{1'b0}}, i_send_time};

    // Magnitude of the transit difference, scaled and saturated
    assign w_d_fwd = r_s1_transit - r_prev_transit;
    assign w_d_rev = r_prev_transit - r_s1_transit;
    assign w_mag   = w_d_fwd[TIME_WIDTH-1] ? w_d_rev : w_d_fwd;
    assign w_mag64 = 64'(w_mag);
    assign w_dv    = (w_mag64 > pgjs_pkg::DV_LIMIT) ? pgjs_pkg::ACC_MAX
                                                    : JW'(w_mag64 << pgjs_pkg::FRAC_BITS);

    // Missing ids between neighbors, signed
    assign w_lost = {2'b00, r_s1_id} - {2'b00, r_prev_id} - DW'(1);

    // Lost total with saturation, gap counter
    assign w_lost_pos = !r_s2_lost[DW-1] && (r_s2_lost != '0);
    assign w_lost_sum = {r_lost_total[LW-1], r_lost_total}
                      + {{(LW+1-DW){r_s2_lost[DW-1]}}, r_s2_lost};

    // Jitter smoothing step, truncated toward zero
    assign w_sh    = (r_shift > pgjs_pkg::SHIFT_MAX) ? pgjs_pkg::SHIFT_MAX : r_shift;
    assign w_up    = {1'b0, r_s2_dv} - {1'b0, r_jitter_acc};
    assign w_ge    = !w_up[JW];
    assign w_jdiff = w_ge ? w_up[JW-1:0] : (r_jitter_acc - r_s2_dv);
    assign w_jstep = w_jdiff >> w_sh;

    always_comb begin
        n_gap_count  = r_gap_count;
        n_lost_total = r_lost_total;
        n_jitter_acc = r_jitter_acc;
        if (r_s2_vld && r_s2_has) begin
            if (w_lost_pos && (r_gap_count != pgjs_pkg::GAP_MAX)) begin
                n_gap_count = r_gap_count + CW'(1);
            end
            priority if (w_lost_sum[LW] == w_lost_sum[LW-1]) begin
                n_lost_total = w_lost_sum[LW-1:0];
            end else if (!w_lost_sum[LW]) begin
                n_lost_total = pgjs_pkg::LOST_MAX;
            end else begin
                n_lost_total = pgjs_pkg::LOST_MIN;
            end
            n_jitter_acc = w_ge ? (r_jitter_acc + w_jstep) : (r_jitter_acc - w_jstep);
        end
    end

    // Restoring divide step on the magnitude of the lost total
    assign w_rshift = {r_rem, r_dvd[LW-1]};
    assign w_qbit   = (w_rshift >= {1'b0, r_fin_gap});

    assign o_sts.batch_end = r_s2_vld && r_s2_last;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift      <= pgjs_pkg::SHIFT_RESET;
            r_s1_vld     <= 1'b0;
            r_s2_vld     <= 1'b0;
            r_has_prev   <= 1'b0;
            r_gap_count  <= '0;
            r_lost_total <= '0;
            r_jitter_acc <= '0;
        end else begin
            if (i_cfg_we) begin
                r_shift <= i_cfg_wdata;
            end
            r_s1_vld <= i_cmd.load;
            r_s2_vld <= r_s1_vld;
            if (r_s1_vld) begin
                r_has_prev <= !r_s1_last;
            end
            // Clear the batch after its final record
            if (r_s2_vld && r_s2_last) begin
                r_gap_count  <= '0;
                r_lost_total <= '0;
                r_jitter_acc <= '0;
            end else begin
                r_gap_count  <= n_gap_count;
                r_lost_total <= n_lost_total;
                r_jitter_acc <= n_jitter_acc;
            end
        end
    end

    // Payload pipeline
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_s1_id      <= i_seq_id;
            r_s1_last    <= i_last;
            r_s1_transit <= w_transit_wide[TIME_WIDTH-1:0];
        end
        if (r_s1_vld) begin
            r_prev_id      <= r_s1_id;
            r_prev_transit <= r_s1_transit;
            r_s2_has       <= r_has_prev;
            r_s2_last      <= r_s1_last;
            r_s2_lost      <= w_lost;
            r_s2_dv        <= w_dv;
        end
        if (r_s2_vld && r_s2_last) begin
            r_fin_lost <= n_lost_total;
            r_fin_gap  <= n_gap_count;
            r_jit_out  <= n_jitter_acc;
        end
    end

    // Divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_neg <= r_fin_lost[LW-1];
            r_dvd <= r_fin_lost[LW-1] ? (LW'(0) - r_fin_lost) : r_fin_lost;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= w_qbit ? CW'(w_rshift - {1'b0, r_fin_gap}) : w_rshift[CW-1:0];
            r_dvd <= {r_dvd[LW-2:0], w_qbit};
        end
        if (i_cmd.div_finish) begin
            if (r_fin_gap == '0) begin
                r_mean_gap <= '0;
            end else if (r_neg) begin
                r_mean_gap <= pgjs_pkg::GAP_W'(0) - r_dvd[pgjs_pkg::GAP_W-1:0];
            end else begin
                r_mean_gap <= r_dvd[pgjs_pkg::GAP_W-1:0];
            end
        end
    end

    assign o_mean_gap     = r_mean_gap;
    assign o_jitter_fixed = r_jit_out;

endmodule

`default_nettype wire

// ===== rtl/packet_gap_and_jitter_stats_top.sv =====
`default_nettype none

// Throughput: one record per cycle within a batch; the first record of the next
// batch is taken in the cycle after the result is accepted.
// After the final record is taken, the result is valid once the batch drains and the
// 33-step restoring divider has computed the mean gap.
// Reset (synchronous, active low): statistics clear, jitter_shift returns to 4.
module packet_gap_and_jitter_stats_top #(
    parameter int TIME_WIDTH = pgjs_pkg::TIME_WIDTH
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire  [pgjs_pkg::SHIFT_W-1:0]     i_cfg_wdata,
    pgjs_rec_if.sink                         i_rec,
    pgjs_res_if.source                       o_res
);

    pgjs_pkg::t_cmd w_cmd;
    pgjs_pkg::t_sts w_sts;

    pgjs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_rec.valid),
        .i_last_hint (i_rec.last),
        .o_in_ready  (i_rec.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    pgjs_dp #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_seq_id       (i_rec.seq_id),
        .i_send_time    (i_rec.send_time),
        .i_recv_time    (i_rec.recv_time),
        .i_last         (i_rec.last),
        .o_mean_gap     (o_res.mean_gap),
        .o_jitter_fixed (o_res.jitter_fixed)
    );

endmodule

`default_nettype wire
